// ----- hw/rtl/pff_pkg.sv -----
package pff_pkg;

  // Operand widths fixed by the field formats
  localparam int unsigned POS_W   = 32;
  localparam int unsigned NRM_W   = 16;
  localparam int unsigned D_W     = 33;
  localparam int unsigned PROD_W  = 49;   // normal component times d
  localparam int unsigned DOT_W   = 51;   // sum of three products
  localparam int unsigned P_W     = 49;   // positive dot product
  localparam int unsigned SQ_W    = 65;   // |d|^2 per axis
  localparam int unsigned LEN2_W  = 66;
  localparam int unsigned AREA_W  = 32;
  localparam int unsigned P12_W   = 98;   // p1*p2
  localparam int unsigned NUM_W   = 130;  // p1*p2*area
  localparam int unsigned L2SQ_W  = 132;  // len2^2
  localparam int unsigned DEN_W   = 164;  // pi*len2^2
  localparam int unsigned PI_W    = 32;
  localparam int unsigned Q_BITS  = 32;

  // Multiplier chain geometry: one 16-bit digit of B per cell
  localparam int unsigned CHUNK   = 16;
  localparam int unsigned MB1_W   = 80;   // padded B width, first multiply pair
  localparam int unsigned MB2_W   = 144;  // padded B width, second multiply pair

  // round(pi * 2^30)
  localparam logic [PI_W-1:0] PI_Q30 = 32'd3373259426;

  typedef struct packed {
    logic              vis;
    logic              sat;
    logic [Q_BITS-1:0] q;
  } div_t;

  typedef struct packed {
    logic [Q_BITS-1:0] form_factor;
    logic              mutually_visible;
    logic              saturated;
  } res_t;

endpackage

// ----- hw/rtl/pff_if.sv -----
interface pff_in_if;
  logic                valid;
  logic                ready;
  logic signed [31:0]  orig_pos_x;
  logic signed [31:0]  orig_pos_y;
  logic signed [31:0]  orig_pos_z;
  logic signed [31:0]  dest_pos_x;
  logic signed [31:0]  dest_pos_y;
  logic signed [31:0]  dest_pos_z;
  logic        [47:0]  orig_normal;
  logic        [47:0]  dest_normal;
  logic        [31:0]  patch_area;

  modport source (
    output valid, orig_pos_x, orig_pos_y, orig_pos_z, dest_pos_x, dest_pos_y, dest_pos_z,
           orig_normal, dest_normal, patch_area,
    input  ready
  );
  modport sink (
    input  valid, orig_pos_x, orig_pos_y, orig_pos_z, dest_pos_x, dest_pos_y, dest_pos_z,
           orig_normal, dest_normal, patch_area,
    output ready
  );
endinterface

interface pff_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] form_factor;
  logic        mutually_visible;
  logic        saturated;

  modport source (
    output valid, form_factor, mutually_visible, saturated,
    input  ready
  );
  modport sink (
    input  valid, form_factor, mutually_visible, saturated,
    output ready
  );
endinterface

// ----- hw/rtl/pff_mul_cell.sv -----
module pff_mul_cell #(
  parameter int unsigned AW  = 32,
  parameter int unsigned BW  = 80,
  parameter int unsigned SW  = 1,
  parameter int unsigned IDX = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  input  logic [AW+BW-1:0] acc_i,
  input  logic [SW-1:0]    side_i,
  output logic [AW-1:0]    a_o,
  output logic [BW-1:0]    b_o,
  output logic [AW+BW-1:0] acc_o,
  output logic [SW-1:0]    side_o
);

  localparam int unsigned PW = AW + BW;

  logic [PW-1:0] pp;

  // partial product of A and the low digit of B, placed at this cell's weight
  assign pp = (PW'(a_i) * PW'(b_i[pff_pkg::CHUNK-1:0])) << (IDX * pff_pkg::CHUNK);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_o    <= a_i;
      b_o    <= b_i >> pff_pkg::CHUNK;
      acc_o  <= acc_i + pp;
      side_o <= side_i;
    end
  end

endmodule

// ----- hw/rtl/pff_mul.sv -----
module pff_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 80,
  parameter int unsigned SW = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  input  logic [SW-1:0]    side_i,
  output logic [AW+BW-1:0] prod_o,
  output logic [SW-1:0]    side_o
);

  localparam int unsigned NC = BW / pff_pkg::CHUNK;

  logic [AW-1:0]    a_w    [NC+1];
  logic [BW-1:0]    b_w    [NC+1];
  logic [AW+BW-1:0] acc_w  [NC+1];
  logic [SW-1:0]    side_w [NC+1];

  assign a_w[0]    = a_i;
  assign b_w[0]    = b_i;
  assign acc_w[0]  = '0;
  assign side_w[0] = side_i;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    pff_mul_cell #(.AW(AW), .BW(BW), .SW(SW), .IDX(k)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en_i),
      .a_i    (a_w[k]),
      .b_i    (b_w[k]),
      .acc_i  (acc_w[k]),
      .side_i (side_w[k]),
      .a_o    (a_w[k+1]),
      .b_o    (b_w[k+1]),
      .acc_o  (acc_w[k+1]),
      .side_o (side_w[k+1])
    );
  end

  assign prod_o = acc_w[NC];
  assign side_o = side_w[NC];

endmodule

// ----- hw/rtl/pff_div_cell.sv -----
module pff_div_cell #(
  parameter int unsigned RW = 197,
  parameter int unsigned K  = 32
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [RW-1:0]             rem_i,
  input  logic [pff_pkg::DEN_W-1:0] den_i,
  input  pff_pkg::div_t             ctl_i,
  output logic [RW-1:0]             rem_o,
  output logic [pff_pkg::DEN_W-1:0] den_o,
  output pff_pkg::div_t             ctl_o
);

  logic [RW-1:0] den_sh;
  logic          ge;
  pff_pkg::div_t ctl_d;

  assign den_sh = RW'(den_i) << K;
  assign ge     = (rem_i >= den_sh);

  // top cell only detects a quotient of 2^32 or more
  if (K >= pff_pkg::Q_BITS) begin : g_ovf
    always_comb begin
      ctl_d     = ctl_i;
      ctl_d.sat = ge;
    end
  end else begin : g_bit
    always_comb begin
      ctl_d      = ctl_i;
      ctl_d.q[K] = ge;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= ge ? (rem_i - den_sh) : rem_i;
      den_o <= den_i;
      ctl_o <= ctl_d;
    end
  end

endmodule

// ----- hw/rtl/point_form_factor.sv -----
// Point-to-point differential form factor, fully pipelined.
// Pipeline: 3 front stages, two 5-cell and two 9-cell multiplier chains,
// 33 divider cells, output reg. Throughput: one transfer per cycle while the
// skid slot is empty; a skid stage absorbs one result on stall.
// Reset (rst_ni low, async): all valid flags cleared; payload is not reset.
module point_form_factor #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  pff_in_if.sink  in_i,
  pff_out_if.source out_o
);

  // ---------------------------------------------------------------------------
  // Geometry
  // ---------------------------------------------------------------------------
  localparam int unsigned SH    = 2 * FRACTION_BITS + 2;        // numerator scale
  localparam int unsigned NW    = pff_pkg::NUM_W + SH;
  localparam int unsigned DSW   = pff_pkg::DEN_W + pff_pkg::Q_BITS + 1;
  localparam int unsigned RW    = (NW > DSW) ? NW : DSW;        // remainder width
  localparam int unsigned NDIV  = pff_pkg::Q_BITS + 1;          // 32 quotient bits + ovf
  localparam int unsigned LAT_M = (pff_pkg::MB1_W + pff_pkg::MB2_W) / pff_pkg::CHUNK;
  localparam int unsigned LAT   = 3 + LAT_M + NDIV;             // pipeline depth

  // Whole pipe advances together; it stalls only when the skid slot is full.
  logic           en;
  logic [LAT-1:0] v_q;
  logic           skid_v_q, out_v_q;
  pff_pkg::res_t  skid_q, out_q, tail;

  assign en         = !skid_v_q;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], in_i.valid};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: d = dest - orig (33-bit exact)
  // ---------------------------------------------------------------------------
  logic signed [pff_pkg::D_W-1:0] d1_q [3];
  logic [47:0]                    no1_q, nd1_q;
  logic [pff_pkg::AREA_W-1:0]     area1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q[0] <= $signed({in_i.dest_pos_x[31], in_i.dest_pos_x})
               - $signed({in_i.orig_pos_x[31], in_i.orig_pos_x});
      d1_q[1] <= $signed({in_i.dest_pos_y[31], in_i.dest_pos_y})
               - $signed({in_i.orig_pos_y[31], in_i.orig_pos_y});
      d1_q[2] <= $signed({in_i.dest_pos_z[31], in_i.dest_pos_z})
               - $signed({in_i.orig_pos_z[31], in_i.orig_pos_z});
      no1_q   <= in_i.orig_normal;
      nd1_q   <= in_i.dest_normal;
      area1_q <= in_i.patch_area;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: per-axis normal products and squared magnitudes
  // ---------------------------------------------------------------------------
  logic signed [pff_pkg::PROD_W-1:0] po2_q [3];
  logic signed [pff_pkg::PROD_W-1:0] pd2_q [3];
  logic        [pff_pkg::SQ_W-1:0]   sq2_q [3];
  logic        [pff_pkg::AREA_W-1:0] area2_q;
  logic        [pff_pkg::D_W-1:0]    mag   [3];
  logic signed [pff_pkg::NRM_W-1:0]  no_c  [3];
  logic signed [pff_pkg::NRM_W-1:0]  nd_c  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      no_c[k] = $signed(no1_q[k*pff_pkg::NRM_W +: pff_pkg::NRM_W]);
      nd_c[k] = $signed(nd1_q[k*pff_pkg::NRM_W +: pff_pkg::NRM_W]);
      mag[k]  = d1_q[k][pff_pkg::D_W-1] ? pff_pkg::D_W'(-d1_q[k]) : pff_pkg::D_W'(d1_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        po2_q[k] <= no_c[k] * d1_q[k];
        pd2_q[k] <= nd_c[k] * d1_q[k];
        sq2_q[k] <= pff_pkg::SQ_W'(mag[k]) * pff_pkg::SQ_W'(mag[k]);
      end
      area2_q <= area1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: p1, p2, len2 and the facing test
  // ---------------------------------------------------------------------------
  logic signed [pff_pkg::DOT_W-1:0] dot1, dot2;
  logic                             vis3;
  logic [pff_pkg::P_W-1:0]          p1_q, p2_q;
  logic [pff_pkg::LEN2_W-1:0]       len2_q;
  logic [pff_pkg::AREA_W-1:0]       area3_q;
  logic                             vis3_q;

  assign dot1 = pff_pkg::DOT_W'(po2_q[0]) + pff_pkg::DOT_W'(po2_q[1])
              + pff_pkg::DOT_W'(po2_q[2]);
  assign dot2 = -(pff_pkg::DOT_W'(pd2_q[0]) + pff_pkg::DOT_W'(pd2_q[1])
              + pff_pkg::DOT_W'(pd2_q[2]));
  assign vis3 = (dot1 > 0) && (dot2 > 0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      // facing away: zero operands so nothing downstream matters but vis
      p1_q    <= vis3 ? dot1[pff_pkg::P_W-1:0] : '0;
      p2_q    <= vis3 ? dot2[pff_pkg::P_W-1:0] : '0;
      len2_q  <= pff_pkg::LEN2_W'(sq2_q[0]) + pff_pkg::LEN2_W'(sq2_q[1])
               + pff_pkg::LEN2_W'(sq2_q[2]);
      area3_q <= area2_q;
      vis3_q  <= vis3;
    end
  end

  // ---------------------------------------------------------------------------
  // Multiplier chains: p1*p2 and len2^2, then *area and *pi
  // ---------------------------------------------------------------------------
  logic [pff_pkg::P_W+pff_pkg::MB1_W-1:0]    m1_prod;
  logic [pff_pkg::LEN2_W+pff_pkg::MB1_W-1:0] m2_prod;
  logic [pff_pkg::AREA_W-1:0]                m1_area;
  logic                                      m2_vis;
  logic [pff_pkg::AREA_W+pff_pkg::MB2_W-1:0] m3_prod;
  logic [pff_pkg::PI_W+pff_pkg::MB2_W-1:0]   m4_prod;
  logic                                      m3_vis, m4_vis;

  pff_mul #(.AW(pff_pkg::P_W), .BW(pff_pkg::MB1_W), .SW(pff_pkg::AREA_W)) u_m1 (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (p1_q),
    .b_i    (pff_pkg::MB1_W'(p2_q)),
    .side_i (area3_q),
    .prod_o (m1_prod),
    .side_o (m1_area)
  );

  pff_mul #(.AW(pff_pkg::LEN2_W), .BW(pff_pkg::MB1_W), .SW(1)) u_m2 (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (len2_q),
    .b_i    (pff_pkg::MB1_W'(len2_q)),
    .side_i (vis3_q),
    .prod_o (m2_prod),
    .side_o (m2_vis)
  );

  pff_mul #(.AW(pff_pkg::AREA_W), .BW(pff_pkg::MB2_W), .SW(1)) u_m3 (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (m1_area),
    .b_i    (pff_pkg::MB2_W'(m1_prod[pff_pkg::P12_W-1:0])),
    .side_i (m2_vis),
    .prod_o (m3_prod),
    .side_o (m3_vis)
  );

  pff_mul #(.AW(pff_pkg::PI_W), .BW(pff_pkg::MB2_W), .SW(1)) u_m4 (
    .clk_i  (clk_i),
    .en_i   (en),
    .a_i    (pff_pkg::PI_Q30),
    .b_i    (pff_pkg::MB2_W'(m2_prod[pff_pkg::L2SQ_W-1:0])),
    .side_i (m2_vis),
    .prod_o (m4_prod),
    .side_o (m4_vis)
  );

  // ---------------------------------------------------------------------------
  // Restoring divider: one quotient bit per cell, MSB (overflow) first
  // ---------------------------------------------------------------------------
  logic [RW-1:0]                rem_w [NDIV+1];
  logic [pff_pkg::DEN_W-1:0]    den_w [NDIV+1];
  pff_pkg::div_t                ctl_w [NDIV+1];

  assign rem_w[0] = RW'(m3_prod[pff_pkg::NUM_W-1:0]) << SH;
  assign den_w[0] = m4_prod[pff_pkg::DEN_W-1:0];

  always_comb begin
    ctl_w[0]     = '0;
    ctl_w[0].vis = m3_vis & m4_vis;
  end

  for (genvar j = 0; j < NDIV; j++) begin : g_div
    pff_div_cell #(.RW(RW), .K(pff_pkg::Q_BITS - j)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (rem_w[j]),
      .den_i (den_w[j]),
      .ctl_i (ctl_w[j]),
      .rem_o (rem_w[j+1]),
      .den_o (den_w[j+1]),
      .ctl_o (ctl_w[j+1])
    );
  end

  // Final result; not visible masks the (meaningless) quotient and overflow.
  always_comb begin
    tail.mutually_visible = ctl_w[NDIV].vis;
    tail.saturated        = ctl_w[NDIV].vis & ctl_w[NDIV].sat;
    if (!ctl_w[NDIV].vis) begin
      tail.form_factor = '0;
    end else if (ctl_w[NDIV].sat) begin
      tail.form_factor = '1;
    end else begin
      tail.form_factor = ctl_w[NDIV].q;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register plus skid slot
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || out_o.ready) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= v_q[LAT-1];
      end
    end else if (v_q[LAT-1] && en) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || out_o.ready) begin
      out_q <= skid_v_q ? skid_q : tail;
    end else if (v_q[LAT-1] && en) begin
      skid_q <= tail;
    end
  end

  assign out_o.valid            = out_v_q;
  assign out_o.form_factor      = out_q.form_factor;
  assign out_o.mutually_visible = out_q.mutually_visible;
  assign out_o.saturated        = out_q.saturated;

endmodule
